### hdl/bbr_pkg.sv
// shared types and constants for the breadth-first renumbering block
// no dependencies
`default_nettype none
package bbr_pkg;

  localparam int MAX_CELLS = 1024;
  localparam int MAX_EDGES = 8192;
  localparam int CELL_W    = $clog2(MAX_CELLS);
  localparam int CNT_W     = CELL_W + 1;
  localparam int EADDR_W   = $clog2(MAX_EDGES);
  localparam int EDGE_W    = EADDR_W + 1;

  localparam logic [1:0] MODE_ADD   = 2'd0;
  localparam logic [1:0] MODE_CLOSE = 2'd1;
  localparam logic [1:0] MODE_RUN   = 2'd2;
  localparam logic [1:0] MODE_READ  = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_RD_ISSUE,
    S_RD_DONE,
    S_CLR_INIT,
    S_CLR,
    S_SCAN_RD,
    S_SCAN_CK,
    S_DEQ,
    S_CUR,
    S_HI,
    S_LO,
    S_EDGE,
    S_NB,
    S_VIS,
    S_RUN_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_RD_ISSUE,
    OP_RD_DONE,
    OP_CLR_INIT,
    OP_CLR,
    OP_SCAN_RD,
    OP_SCAN_CK,
    OP_DEQ,
    OP_CUR,
    OP_HI,
    OP_LO,
    OP_EDGE,
    OP_NB,
    OP_VIS,
    OP_RUN_DONE
  } dp_op_t;

  typedef struct packed {
    logic   capture;
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic idx_end;
    logic unvisited;
    logic has_work;
    logic edge_more;
    logic nb_bad;
  } status_t;

endpackage
`default_nettype wire

### hdl/bfs_band_reducing_renumbering.sv
// top level of the breadth-first renumbering block: controller plus datapath
// depends on bbr_pkg, bbr_ctrl, bbr_datapath
//
// An item is taken when start is high and busy is low; its one result shows
// on cell_res, count and error while done is high for a single cycle, and the
// receiver cannot stall it. Add and close items pass through the load state,
// read items through the read issue and read done states. A run first clears
// the visited mark of every one of the MAX_CELLS entries, then scans the
// loaded cells in order and walks breadth-first from each unvisited one,
// checking each neighbour entry of a closed cell that it takes from the queue.
`default_nettype none
module bfs_band_reducing_renumbering (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [1:0]                 mode,
  input  wire logic [bbr_pkg::CELL_W-1:0] neighbour,
  input  wire logic [bbr_pkg::CELL_W-1:0] position,
  output logic                            done,
  output logic [bbr_pkg::CELL_W-1:0]      cell_res,
  output logic [bbr_pkg::CNT_W-1:0]       count,
  output logic                            error
);

  bbr_pkg::cmd_t    cmd;
  bbr_pkg::status_t status;

  bbr_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .mode   (mode),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  bbr_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .mode      (mode),
    .neighbour (neighbour),
    .position  (position),
    .status    (status),
    .done      (done),
    .cell_res  (cell_res),
    .count     (count),
    .error     (error)
  );

endmodule
`default_nettype wire

### hdl/bbr_ctrl.sv
// controller state machine sequencing load, read and ordering runs
// depends on bbr_pkg
`default_nettype none
module bbr_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [1:0]       mode,
  input  wire bbr_pkg::status_t status,
  output bbr_pkg::cmd_t         cmd,
  output logic                  busy
);

  bbr_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bbr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      bbr_pkg::S_IDLE: begin
        if (start) begin
          case (mode)
            bbr_pkg::MODE_RUN:  state_next = bbr_pkg::S_CLR_INIT;
            bbr_pkg::MODE_READ: state_next = bbr_pkg::S_RD_ISSUE;
            default:            state_next = bbr_pkg::S_LOAD;
          endcase
        end
      end
      bbr_pkg::S_LOAD:     state_next = bbr_pkg::S_IDLE;
      bbr_pkg::S_RD_ISSUE: state_next = bbr_pkg::S_RD_DONE;
      bbr_pkg::S_RD_DONE:  state_next = bbr_pkg::S_IDLE;
      bbr_pkg::S_CLR_INIT: state_next = bbr_pkg::S_CLR;
      bbr_pkg::S_CLR: begin
        if (status.clr_last) state_next = bbr_pkg::S_SCAN_RD;
      end
      bbr_pkg::S_SCAN_RD: begin
        state_next = status.idx_end ? bbr_pkg::S_RUN_DONE : bbr_pkg::S_SCAN_CK;
      end
      bbr_pkg::S_SCAN_CK: begin
        state_next = status.unvisited ? bbr_pkg::S_DEQ : bbr_pkg::S_SCAN_RD;
      end
      bbr_pkg::S_DEQ: begin
        state_next = status.has_work ? bbr_pkg::S_CUR : bbr_pkg::S_SCAN_RD;
      end
      bbr_pkg::S_CUR: state_next = bbr_pkg::S_HI;
      bbr_pkg::S_HI:  state_next = bbr_pkg::S_LO;
      bbr_pkg::S_LO:  state_next = bbr_pkg::S_EDGE;
      bbr_pkg::S_EDGE: begin
        state_next = status.edge_more ? bbr_pkg::S_NB : bbr_pkg::S_DEQ;
      end
      bbr_pkg::S_NB: begin
        state_next = status.nb_bad ? bbr_pkg::S_EDGE : bbr_pkg::S_VIS;
      end
      bbr_pkg::S_VIS:      state_next = bbr_pkg::S_EDGE;
      bbr_pkg::S_RUN_DONE: state_next = bbr_pkg::S_IDLE;
      default:             state_next = bbr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    busy        = (state != bbr_pkg::S_IDLE);
    cmd.capture = (state == bbr_pkg::S_IDLE) && start;
    case (state)
      bbr_pkg::S_LOAD:     cmd.op = bbr_pkg::OP_LOAD;
      bbr_pkg::S_RD_ISSUE: cmd.op = bbr_pkg::OP_RD_ISSUE;
      bbr_pkg::S_RD_DONE:  cmd.op = bbr_pkg::OP_RD_DONE;
      bbr_pkg::S_CLR_INIT: cmd.op = bbr_pkg::OP_CLR_INIT;
      bbr_pkg::S_CLR:      cmd.op = bbr_pkg::OP_CLR;
      bbr_pkg::S_SCAN_RD:  cmd.op = bbr_pkg::OP_SCAN_RD;
      bbr_pkg::S_SCAN_CK:  cmd.op = bbr_pkg::OP_SCAN_CK;
      bbr_pkg::S_DEQ:      cmd.op = bbr_pkg::OP_DEQ;
      bbr_pkg::S_CUR:      cmd.op = bbr_pkg::OP_CUR;
      bbr_pkg::S_HI:       cmd.op = bbr_pkg::OP_HI;
      bbr_pkg::S_LO:       cmd.op = bbr_pkg::OP_LO;
      bbr_pkg::S_EDGE:     cmd.op = bbr_pkg::OP_EDGE;
      bbr_pkg::S_NB:       cmd.op = bbr_pkg::OP_NB;
      bbr_pkg::S_VIS:      cmd.op = bbr_pkg::OP_VIS;
      bbr_pkg::S_RUN_DONE: cmd.op = bbr_pkg::OP_RUN_DONE;
      default:             cmd.op = bbr_pkg::OP_NONE;
    endcase
  end

endmodule
`default_nettype wire

### hdl/bbr_datapath.sv
// datapath: graph, visited and order memories, counters and result registers
// depends on bbr_pkg
`default_nettype none
module bbr_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire bbr_pkg::cmd_t               cmd,
  input  wire logic [1:0]                  mode,
  input  wire logic [bbr_pkg::CELL_W-1:0]  neighbour,
  input  wire logic [bbr_pkg::CELL_W-1:0]  position,
  output bbr_pkg::status_t                 status,
  output logic                             done,
  output logic [bbr_pkg::CELL_W-1:0]       cell_res,
  output logic [bbr_pkg::CNT_W-1:0]        count,
  output logic                             error
);

  localparam int CW = bbr_pkg::CELL_W;
  localparam int NW = bbr_pkg::CNT_W;
  localparam int EW = bbr_pkg::EDGE_W;
  localparam int AW = bbr_pkg::EADDR_W;

  logic [EW-1:0] list_mem  [bbr_pkg::MAX_CELLS];
  logic [CW-1:0] nb_mem    [bbr_pkg::MAX_EDGES];
  logic          vis_mem   [bbr_pkg::MAX_CELLS];
  logic [CW-1:0] order_mem [bbr_pkg::MAX_CELLS];

  logic [1:0]    mode_q;
  logic [CW-1:0] nb_q, pos_q;
  logic [NW-1:0] cell_total, ordered, idx, head, tail;
  logic [EW-1:0] edge_total, e, ehi;
  logic          err, ran;
  logic [CW-1:0] cur, nbq;

  logic [EW-1:0] list_rd;
  logic [CW-1:0] nb_rd, order_rd;
  logic          vis_rd;

  logic [NW-1:0] ct_eff;
  logic [EW-1:0] et_eff;
  logic          err_eff;

  logic          list_we, nb_we, vis_we, vis_wd, order_we;
  logic [CW-1:0] list_wa, list_ra, vis_wa, vis_ra, order_wa, order_ra, order_wd;
  logic [AW-1:0] nb_ra;

  assign ct_eff  = ran ? '0 : cell_total;
  assign et_eff  = ran ? '0 : edge_total;
  assign err_eff = ran ? 1'b0 : err;

  always_comb begin
    status.clr_last  = (idx == NW'(bbr_pkg::MAX_CELLS - 1));
    status.idx_end   = (idx == cell_total);
    status.unvisited = !vis_rd;
    status.has_work  = (head < tail);
    status.edge_more = (e < ehi);
    status.nb_bad    = ({1'b0, nb_rd} >= cell_total);
  end

  // memory port steering
  always_comb begin
    list_we  = (cmd.op == bbr_pkg::OP_LOAD) && (mode_q == bbr_pkg::MODE_CLOSE)
               && (ct_eff < NW'(bbr_pkg::MAX_CELLS));
    list_wa  = ct_eff[CW-1:0];
    list_ra  = (cmd.op == bbr_pkg::OP_CUR) ? order_rd : cur - 1'b1;
    nb_we    = (cmd.op == bbr_pkg::OP_LOAD) && (mode_q == bbr_pkg::MODE_ADD)
               && (ct_eff < NW'(bbr_pkg::MAX_CELLS))
               && (et_eff < EW'(bbr_pkg::MAX_EDGES));
    nb_ra    = e[AW-1:0];
    vis_we   = 1'b0;
    vis_wd   = 1'b0;
    vis_wa   = idx[CW-1:0];
    order_we = 1'b0;
    order_wa = tail[CW-1:0];
    order_wd = idx[CW-1:0];
    case (cmd.op)
      bbr_pkg::OP_CLR: vis_we = 1'b1;
      bbr_pkg::OP_SCAN_CK: begin
        vis_we   = !vis_rd;
        vis_wd   = 1'b1;
        order_we = !vis_rd;
      end
      bbr_pkg::OP_VIS: begin
        vis_we   = !vis_rd;
        vis_wd   = 1'b1;
        vis_wa   = nbq;
        order_we = !vis_rd;
        order_wd = nbq;
      end
      default: ;
    endcase
    vis_ra   = (cmd.op == bbr_pkg::OP_NB) ? nb_rd : idx[CW-1:0];
    order_ra = (cmd.op == bbr_pkg::OP_RD_ISSUE) ? pos_q : head[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (list_we) list_mem[list_wa] <= et_eff;
    list_rd <= list_mem[list_ra];
  end

  always_ff @(posedge clk) begin
    if (nb_we) nb_mem[et_eff[AW-1:0]] <= nb_q;
    nb_rd <= nb_mem[nb_ra];
  end

  always_ff @(posedge clk) begin
    if (vis_we) vis_mem[vis_wa] <= vis_wd;
    vis_rd <= vis_mem[vis_ra];
  end

  always_ff @(posedge clk) begin
    if (order_we) order_mem[order_wa] <= order_wd;
    order_rd <= order_mem[order_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_q <= mode;
      nb_q   <= neighbour;
      pos_q  <= position;
    end
    case (cmd.op)
      bbr_pkg::OP_CLR_INIT: begin
        idx  <= '0;
        head <= '0;
        tail <= '0;
      end
      bbr_pkg::OP_CLR:     idx <= status.clr_last ? '0 : idx + 1'b1;
      bbr_pkg::OP_SCAN_CK: begin
        if (!vis_rd) tail <= tail + 1'b1;
        else idx <= idx + 1'b1;
      end
      bbr_pkg::OP_DEQ: begin
        if (head < tail) head <= head + 1'b1;
        else idx <= idx + 1'b1;
      end
      bbr_pkg::OP_CUR:  cur <= order_rd;
      bbr_pkg::OP_HI:   ehi <= list_rd;
      bbr_pkg::OP_LO:   e <= (cur == '0) ? '0 : list_rd;
      bbr_pkg::OP_EDGE: e <= e + 1'b1;
      bbr_pkg::OP_NB:   nbq <= nb_rd;
      bbr_pkg::OP_VIS: begin
        if (!vis_rd) tail <= tail + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_total <= '0;
      edge_total <= '0;
      err        <= 1'b0;
      ran        <= 1'b0;
      ordered    <= '0;
      done       <= 1'b0;
      cell_res   <= '0;
      count      <= '0;
      error      <= 1'b0;
    end else begin
      done <= 1'b0;
      case (cmd.op)
        bbr_pkg::OP_LOAD: begin
          ran  <= 1'b0;
          done <= 1'b1;
          cell_res <= '0;
          if (ran) ordered <= '0;
          if (mode_q == bbr_pkg::MODE_ADD) begin
            cell_total <= ct_eff;
            count      <= ct_eff;
            if (nb_we) begin
              edge_total <= et_eff + 1'b1;
              err        <= err_eff;
              error      <= err_eff;
            end else begin
              edge_total <= et_eff;
              err        <= 1'b1;
              error      <= 1'b1;
            end
          end else begin
            edge_total <= et_eff;
            if (list_we) begin
              cell_total <= ct_eff + 1'b1;
              count      <= ct_eff + 1'b1;
              err        <= err_eff;
              error      <= err_eff;
            end else begin
              cell_total <= ct_eff;
              count      <= ct_eff;
              err        <= 1'b1;
              error      <= 1'b1;
            end
          end
        end
        bbr_pkg::OP_RD_DONE: begin
          done  <= 1'b1;
          count <= cell_total;
          if ({1'b0, pos_q} < ordered) begin
            cell_res <= order_rd;
            error    <= err;
          end else begin
            cell_res <= '0;
            err      <= 1'b1;
            error    <= 1'b1;
          end
        end
        bbr_pkg::OP_CLR_INIT: ordered <= '0;
        bbr_pkg::OP_NB: begin
          if (status.nb_bad) err <= 1'b1;
        end
        bbr_pkg::OP_RUN_DONE: begin
          ran      <= 1'b1;
          ordered  <= tail;
          done     <= 1'b1;
          cell_res <= '0;
          count    <= cell_total;
          error    <= err;
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

### hdl/bbr_checker.sv
// port-level checks for the renumbering block, bound to the top level
// depends on bbr_pkg
`default_nettype none
module bbr_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       start,
  input wire logic                       busy,
  input wire logic                       done,
  input wire logic [bbr_pkg::CNT_W-1:0]  count
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("busy low after transfer");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result while busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe too long");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (count <= bbr_pkg::CNT_W'(bbr_pkg::MAX_CELLS)))
    else $error("count out of range");

endmodule

bind bfs_band_reducing_renumbering bbr_checker u_bbr_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .count (count)
);
`default_nettype wire
